// ===== rtl/rrht_pkg.sv =====
package rrht_pkg;

  // Field and register widths
  localparam int unsigned CoordW     = 16;
  localparam int unsigned FracBitsDef = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned NumEdges   = 4;

  // Corner: sum of three 16-bit values
  localparam int unsigned CornerW = CoordW + 2;
  // Half edge vector: negated 16-bit value
  localparam int unsigned HalfW   = CoordW + 1;
  // Point minus corner, bounded by +/-131071
  localparam int unsigned DiffW   = CoordW + 2;
  // Cross product terms
  localparam int unsigned ProdW   = HalfW + DiffW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COS_SCALED = 2'd0,
    CFG_SIN_SCALED = 2'd1,
    CFG_CENTER_X   = 2'd2,
    CFG_CENTER_Y   = 2'd3
  } cfg_reg_e;

  // Square geometry, fixed between configuration writes.
  // Edge i runs from corner i with direction 2*h[i].
  typedef struct packed {
    logic [NumEdges-1:0][CornerW-1:0] ax;
    logic [NumEdges-1:0][CornerW-1:0] ay;
    logic [NumEdges-1:0][HalfW-1:0]   hx;
    logic [NumEdges-1:0][HalfW-1:0]   hy;
  } geom_t;

  // Load enables of the edge test stages
  typedef struct packed {
    logic ld_s2;
    logic ld_s3;
  } pipe_ctrl_t;

endpackage

// ===== rtl/rrht_point_if.sv =====
interface rrht_point_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rrht_pkg::CoordW-1:0]    point_x;
  logic signed [rrht_pkg::CoordW-1:0]    point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ===== rtl/rrht_res_if.sv =====
interface rrht_res_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink   (input valid, input inside_res, output ready);
endinterface

// ===== rtl/rrht_cfg.sv =====
module rrht_cfg #(
  parameter int unsigned FracBits = rrht_pkg::FracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rrht_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [rrht_pkg::CoordW-1:0]         cfg_wdata_i,
  output rrht_pkg::geom_t                     geom_o
);

  localparam logic [rrht_pkg::CoordW-1:0] CosReset = rrht_pkg::CoordW'(1 << FracBits);

  logic [rrht_pkg::CoordW-1:0] cos_q, sin_q, cx_q, cy_q;
  logic signed [rrht_pkg::CornerW-1:0] cs, sn, cx, cy;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= CosReset;
      sin_q <= '0;
      cx_q  <= '0;
      cy_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (rrht_pkg::cfg_reg_e'(cfg_idx_i))
        rrht_pkg::CFG_COS_SCALED: cos_q <= cfg_wdata_i;
        rrht_pkg::CFG_SIN_SCALED: sin_q <= cfg_wdata_i;
        rrht_pkg::CFG_CENTER_X:   cx_q  <= cfg_wdata_i;
        rrht_pkg::CFG_CENTER_Y:   cy_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sign-extend to corner width
  assign cs = rrht_pkg::CornerW'($signed(cos_q));
  assign sn = rrht_pkg::CornerW'($signed(sin_q));
  assign cx = rrht_pkg::CornerW'($signed(cx_q));
  assign cy = rrht_pkg::CornerW'($signed(cy_q));

  // Corners and half edge directions
  always_comb begin
    geom_o.ax[0] = cs - sn + cx;
    geom_o.ay[0] = sn + cs + cy;
    geom_o.ax[1] = -cs - sn + cx;
    geom_o.ay[1] = cs - sn + cy;
    geom_o.ax[2] = sn - cs + cx;
    geom_o.ay[2] = -sn - cs + cy;
    geom_o.ax[3] = cs + sn + cx;
    geom_o.ay[3] = sn - cs + cy;

    geom_o.hx[0] = rrht_pkg::HalfW'(-cs);
    geom_o.hy[0] = rrht_pkg::HalfW'(-sn);
    geom_o.hx[1] = rrht_pkg::HalfW'(sn);
    geom_o.hy[1] = rrht_pkg::HalfW'(-cs);
    geom_o.hx[2] = rrht_pkg::HalfW'(cs);
    geom_o.hy[2] = rrht_pkg::HalfW'(sn);
    geom_o.hx[3] = rrht_pkg::HalfW'(-sn);
    geom_o.hy[3] = rrht_pkg::HalfW'(cs);
  end

endmodule

// ===== rtl/rrht_edge.sv =====
module rrht_edge (
  input  logic                                  clk_i,
  input  rrht_pkg::pipe_ctrl_t                  ctrl_i,
  input  logic signed [rrht_pkg::CoordW-1:0]    px_i,
  input  logic signed [rrht_pkg::CoordW-1:0]    py_i,
  input  logic signed [rrht_pkg::CornerW-1:0]   ax_i,
  input  logic signed [rrht_pkg::CornerW-1:0]   ay_i,
  input  logic signed [rrht_pkg::HalfW-1:0]     hx_i,
  input  logic signed [rrht_pkg::HalfW-1:0]     hy_i,
  output logic                                  pass_o
);

  localparam int unsigned DW = rrht_pkg::DiffW;
  localparam int unsigned HW = rrht_pkg::HalfW;
  localparam int unsigned PW = rrht_pkg::ProdW;

  logic signed [DW-1:0] qx_d, qy_d, qx_q, qy_q;
  logic signed [PW-1:0] lhs_d, rhs_d, lhs_q, rhs_q;
  logic                 behind_d, behind_q;

  // Point relative to the edge start
  assign qx_d = DW'(px_i) - DW'(ax_i);
  assign qy_d = DW'(py_i) - DW'(ay_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_s2) begin
      qx_q <= qx_d;
      qy_q <= qy_d;
    end
  end

  // Cross product terms; behind = some component dot term negative
  assign lhs_d = PW'(hx_i) * PW'(qy_q);
  assign rhs_d = PW'(hy_i) * PW'(qx_q);
  assign behind_d = ((hx_i != '0) && (qx_q != '0) && (hx_i[HW-1] != qx_q[DW-1])) ||
                    ((hy_i != '0) && (qy_q != '0) && (hy_i[HW-1] != qy_q[DW-1]));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_s3) begin
      lhs_q    <= lhs_d;
      rhs_q    <= rhs_d;
      behind_q <= behind_d;
    end
  end

  // Non-negative test: left turn, or collinear and not behind the start
  assign pass_o = (lhs_q > rhs_q) || ((lhs_q == rhs_q) && !behind_q);

endmodule

// ===== rtl/rotated_rect_hit_test_core.sv =====
// Channel   Dir  Payload                         Request accepted when
// pt_in     in   point_x, point_y (s16 Q12.4)    pt_in.valid & pt_in.ready
// res_out   out  inside_res (1 bit)              res_out.valid & res_out.ready
// cfg       in   cfg_idx_i, cfg_wdata_i          cfg_we_i
//
// One request per cycle sustained while res_out.ready stays high.
// Four stages: input register, edge-relative point, cross products, result.
// Each stage loads when empty or when the next one moves, so bubbles close up
// and up to three more requests enter while a result waits on res_out.ready.
// Reset clears all stage valids and loads the register defaults.
module rotated_rect_hit_test_core #(
  parameter int unsigned FracBits = rrht_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rrht_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rrht_pkg::CoordW-1:0]   cfg_wdata_i,
  rrht_point_if.sink                    pt_in,
  rrht_res_if.source                    res_out
);

  rrht_pkg::geom_t      geom;
  rrht_pkg::pipe_ctrl_t ctrl;

  logic v1_q, v2_q, v3_q, vo_q;
  logic v1_d, v2_d, v3_d, vo_d;
  logic ld_s1, ld_out;
  logic in_acc, out_acc;
  logic signed [rrht_pkg::CoordW-1:0] px_q, py_q;
  logic [rrht_pkg::NumEdges-1:0] pass;
  logic inside_q;

  rrht_cfg #(.FracBits(FracBits)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .geom_o      (geom)
  );

  // Stage load enables, back to front
  assign ld_out     = !vo_q || res_out.ready;
  assign ctrl.ld_s3 = !v3_q || ld_out;
  assign ctrl.ld_s2 = !v2_q || ctrl.ld_s3;
  assign ld_s1      = !v1_q || ctrl.ld_s2;

  assign pt_in.ready = ld_s1;
  assign in_acc      = pt_in.valid && ld_s1;
  assign out_acc     = vo_q && res_out.ready;

  // Valid chain
  assign v1_d = ld_s1      ? pt_in.valid : v1_q;
  assign v2_d = ctrl.ld_s2 ? v1_q        : v2_q;
  assign v3_d = ctrl.ld_s3 ? v2_q        : v3_q;
  assign vo_d = ld_out     ? v3_q        : vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      vo_q <= vo_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= pt_in.point_x;
      py_q <= pt_in.point_y;
    end
  end

  // One test per edge of the square
  for (genvar e = 0; e < rrht_pkg::NumEdges; e++) begin : g_edge
    rrht_edge u_edge (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .px_i   (px_q),
      .py_i   (py_q),
      .ax_i   (geom.ax[e]),
      .ay_i   (geom.ay[e]),
      .hx_i   (geom.hx[e]),
      .hy_i   (geom.hy[e]),
      .pass_o (pass[e])
    );
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      inside_q <= &pass;
    end
  end

  assign res_out.valid      = vo_q;
  assign res_out.inside_res = inside_q;

  // Checks
  logic [2:0] occ;
  assign occ = 3'($countones({v1_q, v2_q, v3_q, vo_q}));

  // Items in flight track accepts and deliveries
  a_occ_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> occ == $past(occ) + 3'($past(in_acc)) - 3'($past(out_acc)))
    else $error("in-flight count mismatch");

  // Input is refused only when every stage is occupied
  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pt_in.ready |-> (v1_q && v2_q && v3_q && vo_q))
    else $error("input stalled with a free stage");

  // A held front item stays valid
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !ctrl.ld_s2) |=> v1_q)
    else $error("front stage item lost");

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  // Window with no idling on either side
  localparam int unsigned CalmLo     = 700;
  localparam int unsigned CalmHi     = 1500;

  typedef struct packed {
    logic signed [rrht_pkg::CoordW-1:0] x;
    logic signed [rrht_pkg::CoordW-1:0] y;
  } pt_req_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [rrht_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [rrht_pkg::CoordW-1:0]   cfg_wdata_i;

  rrht_point_if pt_if ();
  rrht_res_if   res_if ();

  rotated_rect_hit_test_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pt_in       (pt_if),
    .res_out     (res_if)
  );

  // Shadow copy of the square registers
  logic signed [rrht_pkg::CoordW-1:0] cos_cfg;
  logic signed [rrht_pkg::CoordW-1:0] sin_cfg;
  logic signed [rrht_pkg::CoordW-1:0] ctr_x_cfg;
  logic signed [rrht_pkg::CoordW-1:0] ctr_y_cfg;

  pt_req_t     pt_req_q[$];
  bit          inside_exp_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cyc = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle count and run limit
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CycleLimit) begin
      $display("%0t: timeout, %0d requests pending, %0d results outstanding", $time,
               pt_req_q.size(), inside_exp_q.size());
      $display("FAIL rotated_rect_hit_test_core");
      $finish;
    end
  end

  function automatic bit take_break();
    if (cyc >= CalmLo && cyc < CalmHi) return 1'b0;
    return $urandom_range(99) < 8;
  endfunction

  // Corners of the square under the current register values
  function automatic void square_corners(output longint xs[4], output longint ys[4]);
    longint cs, sn, cx, cy;
    cs = cos_cfg;
    sn = sin_cfg;
    cx = ctr_x_cfg;
    cy = ctr_y_cfg;
    xs[0] = cs - sn + cx;     ys[0] = sn + cs + cy;
    xs[1] = -cs - sn + cx;    ys[1] = cs - sn + cy;
    xs[2] = -(cs - sn) + cx;  ys[2] = -(sn + cs) + cy;
    xs[3] = cs + sn + cx;     ys[3] = -(cs - sn) + cy;
  endfunction

  // Orientation of p against edge a->b: +1 left or beyond b, -1 right or behind a, 0 on the segment
  function automatic int edge_side(longint ax, longint ay, longint bx, longint by,
                                   longint px, longint py);
    longint ex, ey, qx, qy, lhs, rhs;
    ex  = bx - ax;
    ey  = by - ay;
    qx  = px - ax;
    qy  = py - ay;
    lhs = ex * qy;
    rhs = ey * qx;
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    if (ex * qx < 0 || ey * qy < 0) return -1;
    if (ex * ex + ey * ey < qx * qx + qy * qy) return 1;
    return 0;
  endfunction

  function automatic bit hit_inside(logic signed [rrht_pkg::CoordW-1:0] px,
                                    logic signed [rrht_pkg::CoordW-1:0] py);
    longint xs[4], ys[4];
    int     j;
    square_corners(xs, ys);
    for (int k = 0; k < rrht_pkg::NumEdges; k++) begin
      j = (k + 1) % rrht_pkg::NumEdges;
      if (edge_side(xs[k], ys[k], xs[j], ys[j], px, py) < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Out-of-range coordinates fall back to a random value
  function automatic logic signed [rrht_pkg::CoordW-1:0] fit_coord(longint v);
    if (v >= -32768 && v <= 32767) return v[rrht_pkg::CoordW-1:0];
    return rrht_pkg::CoordW'($urandom);
  endfunction

  function automatic logic signed [rrht_pkg::CoordW-1:0] rand_s16(int unsigned span);
    if (span >= 32768) return rrht_pkg::CoordW'($urandom);
    return rrht_pkg::CoordW'(int'($urandom_range(2 * span)) - int'(span));
  endfunction

  function automatic longint rand_off(int unsigned span);
    return longint'($urandom_range(2 * span)) - longint'(span);
  endfunction

  task automatic push_point(longint x, longint y);
    pt_req_t p;
    p.x = fit_coord(x);
    p.y = fit_coord(y);
    pt_req_q.push_back(p);
  endtask

  // Random point, biased toward corners, edges, their extensions and the center region
  task automatic push_random_point();
    longint xs[4], ys[4];
    longint r, mult;
    int     k, j, t, mode;
    square_corners(xs, ys);
    k    = $urandom_range(3);
    j    = (k + 1) % rrht_pkg::NumEdges;
    mode = $urandom_range(99);
    if (mode < 25) begin
      push_point(rand_s16(32768), rand_s16(32768));
    end else if (mode < 45) begin
      push_point(xs[k] + rand_off(8), ys[k] + rand_off(8));
    end else if (mode < 65) begin
      t = $urandom_range(8);
      if ($urandom_range(1))
        push_point(xs[k] + (xs[j] - xs[k]) * t / 8, ys[k] + (ys[j] - ys[k]) * t / 8);
      else
        push_point(xs[k] + (xs[j] - xs[k]) * t / 8 + rand_off(2),
                   ys[k] + (ys[j] - ys[k]) * t / 8 + rand_off(2));
    end else if (mode < 75) begin
      // exactly collinear with an edge, outside its span
      mult = $urandom_range(1) ? 2 : -1;
      push_point(xs[k] + (xs[j] - xs[k]) * mult, ys[k] + (ys[j] - ys[k]) * mult);
    end else begin
      r = (cos_cfg < 0 ? -longint'(cos_cfg) : longint'(cos_cfg)) +
          (sin_cfg < 0 ? -longint'(sin_cfg) : longint'(sin_cfg)) + 4;
      push_point(longint'(ctr_x_cfg) + rand_off(r), longint'(ctr_y_cfg) + rand_off(r));
    end
  endtask

  // Center, corners, edge midpoints, points collinear past both ends of the first edge
  task automatic push_landmarks();
    longint xs[4], ys[4];
    int     j;
    square_corners(xs, ys);
    push_point(ctr_x_cfg, ctr_y_cfg);
    for (int k = 0; k < rrht_pkg::NumEdges; k++) begin
      j = (k + 1) % rrht_pkg::NumEdges;
      push_point(xs[k], ys[k]);
      push_point(xs[k] + (xs[j] - xs[k]) / 2, ys[k] + (ys[j] - ys[k]) / 2);
    end
    push_point(2 * xs[1] - xs[0], 2 * ys[1] - ys[0]);
    push_point(2 * xs[0] - xs[1], 2 * ys[0] - ys[1]);
  endtask

  task automatic wait_drained();
    while (pt_req_q.size() != 0 || pt_if.valid || inside_exp_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic cfg_write(rrht_pkg::cfg_reg_e idx, logic [rrht_pkg::CoordW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      rrht_pkg::CFG_COS_SCALED: cos_cfg   = val;
      rrht_pkg::CFG_SIN_SCALED: sin_cfg   = val;
      rrht_pkg::CFG_CENTER_X:   ctr_x_cfg = val;
      rrht_pkg::CFG_CENTER_Y:   ctr_y_cfg = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Only called with the block idle
  task automatic set_square(logic [rrht_pkg::CoordW-1:0] cs, logic [rrht_pkg::CoordW-1:0] sn,
                            logic [rrht_pkg::CoordW-1:0] cx, logic [rrht_pkg::CoordW-1:0] cy);
    wait_drained();
    cfg_write(rrht_pkg::CFG_COS_SCALED, cs);
    cfg_write(rrht_pkg::CFG_SIN_SCALED, sn);
    cfg_write(rrht_pkg::CFG_CENTER_X, cx);
    cfg_write(rrht_pkg::CFG_CENTER_Y, cy);
  endtask

  // Random burst with a full drain in the middle
  task automatic run_phase(int unsigned n);
    for (int i = 0; i < n / 2; i++) push_random_point();
    wait_drained();
    for (int i = n / 2; i < n; i++) push_random_point();
  endtask

  // Point sender
  always @(posedge clk_i) begin
    bit      nv;
    pt_req_t np;
    if (!rst_ni) begin
      pt_if.valid <= 1'b0;
    end else begin
      nv = pt_if.valid;
      np = {pt_if.point_x, pt_if.point_y};
      if (pt_if.valid && pt_if.ready) begin
        inside_exp_q.push_back(hit_inside(pt_if.point_x, pt_if.point_y));
        nv = 1'b0;
      end
      if (!nv && pt_req_q.size() != 0 && !take_break()) begin
        np = pt_req_q.pop_front();
        nv = 1'b1;
      end
      pt_if.valid   <= nv;
      pt_if.point_x <= np.x;
      pt_if.point_y <= np.y;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    bit want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (inside_exp_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result, expected none, actual inside_res=%0b",
                   $time, res_if.inside_res);
        end else begin
          want = inside_exp_q.pop_front();
          if (res_if.inside_res !== want) begin
            mismatch_cnt++;
            $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                     $time, want, res_if.inside_res);
          end
        end
      end
      res_if.ready <= !take_break();
    end
  end

  // Stimulus sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = rrht_pkg::CFG_COS_SCALED;
    cfg_wdata_i   = '0;
    pt_if.valid   = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    res_if.ready  = 1'b0;
    cos_cfg       = rrht_pkg::CoordW'(1 << rrht_pkg::FracBitsDef);
    sin_cfg       = 0;
    ctr_x_cfg     = 0;
    ctr_y_cfg     = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Unit square after reset: landmarks and field extremes
    push_landmarks();
    push_point(32767, 32767);
    push_point(-32768, -32768);
    push_point(32767, -32768);
    push_point(-32768, 32767);
    push_point(17, 0);

    // Zero scale: everything counts as inside
    set_square(16'sd0, 16'sd0, 16'sd100, -16'sd100);
    push_landmarks();
    run_phase(20);

    // Negative scale: half-turned square
    set_square(-16'sd80, -16'sd48, 16'sd0, 16'sd0);
    run_phase(30);

    // Register extremes
    set_square(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    run_phase(30);
    set_square(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    run_phase(30);
    set_square(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    run_phase(30);

    // Random squares, mostly moderate size
    for (int ph = 0; ph < 15; ph++) begin
      set_square(rand_s16($urandom_range(9) < 7 ? 2000 : 32768),
                 rand_s16($urandom_range(9) < 7 ? 2000 : 32768),
                 rand_s16($urandom_range(9) < 7 ? 8000 : 32768),
                 rand_s16($urandom_range(9) < 7 ? 8000 : 32768));
      run_phase(96);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && inside_exp_q.size() == 0) begin
      $display("PASS rotated_rect_hit_test_core");
    end else begin
      $display("FAIL rotated_rect_hit_test_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rrht_pkg.sv
rtl/rrht_point_if.sv
rtl/rrht_res_if.sv
rtl/rrht_cfg.sv
rtl/rrht_edge.sv
rtl/rotated_rect_hit_test_core.sv
test/testbench.sv
